[hw/rtl/kmas_pkg.sv]
// ----------------------------------------------------------------------------
// kmas_pkg
// Shared types, constants and helpers of the key matrix autorepeat scanner.
// ----------------------------------------------------------------------------
package kmas_pkg;

    // Number of matrix keys in one scan frame.
    localparam int KEY_COUNT = 56;
    // Bits of a key index, and of a key count that can also hold KEY_COUNT.
    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CNT_W = $clog2(KEY_COUNT + 1);

    // Values that stand in for a zero delay or interval register.
    localparam logic [31:0] DEFAULT_DELAY = 32'd500;
    localparam logic [31:0] DEFAULT_GAP   = 32'd100;

    // Register reset values.
    localparam logic [15:0] RST_DELAY = 16'd500;
    localparam logic [15:0] RST_GAP   = 16'd100;
    localparam logic [7:0]  RST_FN    = 8'd255;
    localparam logic [7:0]  RST_OPT   = 8'd0;
    localparam logic [7:0]  RST_CTRL  = 8'd128;
    localparam logic [7:0]  RST_SHIFT = 8'd129;
    localparam logic [7:0]  RST_ALT   = 8'd130;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DELAY = 3'd0,
        CFG_GAP   = 3'd1,
        CFG_FN    = 3'd2,
        CFG_OPT   = 3'd3,
        CFG_CTRL  = 3'd4,
        CFG_SHIFT = 3'd5,
        CFG_ALT   = 3'd6
    } t_cfg_idx;

    // Modifier flag bit positions.
    localparam int MOD_FN    = 0;
    localparam int MOD_CTRL  = 1;
    localparam int MOD_SHIFT = 2;
    localparam int MOD_ALT   = 3;
    localparam int MOD_OPT   = 4;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_RD,
        ST_MOD_ACC,
        ST_MOD_FIN,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_SUMMARY
    } t_state;

    // One latched key sample.
    typedef struct packed {
        logic       pressed;
        logic [7:0] layer;
        logic [7:0] shifted;
        logic [7:0] base;
    } t_frame_entry;

    // Both timers of one key.
    typedef struct packed {
        logic [31:0] press;
        logic [31:0] rep;
    } t_timer_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic idx_clr;
        logic idx_inc;
        logic mod_acc;
        logic mod_fin;
        logic walk_ev;
        logic flush_wr;
        logic summary;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;
        logic close_flush;
        logic idx_last;
        logic emit_want;
        logic out_free;
    } t_status;

    // Modifier flags that a base code selects; a code may match several.
    function automatic logic [4:0] mod_bits(
        input logic [7:0] code,
        input logic [7:0] fn_code,
        input logic [7:0] ctrl_code,
        input logic [7:0] shift_code,
        input logic [7:0] alt_code,
        input logic [7:0] opt_code
    );
        logic [4:0] m;
        m            = '0;
        m[MOD_FN]    = (code == fn_code);
        m[MOD_CTRL]  = (code == ctrl_code);
        m[MOD_SHIFT] = (code == shift_code);
        m[MOD_ALT]   = (code == alt_code);
        m[MOD_OPT]   = (code == opt_code);
        return m;
    endfunction

endpackage

[hw/rtl/kmas_ram.sv]
// ----------------------------------------------------------------------------
// kmas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kmas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/kmas_ctrl.sv]
// ----------------------------------------------------------------------------
// kmas_ctrl
// Frame sequencer: loads samples, then runs the modifier pass, the key walk
// or the flush pass, and finally issues the frame summary.
// ----------------------------------------------------------------------------
module kmas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kmas_pkg::t_status i_status,
    output kmas_pkg::t_cmd    o_cmd
);
    import kmas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.close) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = i_status.close_flush ? ST_FLUSH_RD : ST_MOD_RD;
                end
            end
            ST_MOD_RD: begin
                n_state = ST_MOD_ACC;
            end
            ST_MOD_ACC: begin
                o_cmd.mod_acc = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_MOD_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_MOD_RD;
                end
            end
            ST_MOD_FIN: begin
                o_cmd.mod_fin = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                n_state = ST_WALK_EV;
            end
            ST_WALK_EV: begin
                // Hold the key while its event waits for room in a full output register.
                if (!i_status.emit_want || i_status.out_free) begin
                    o_cmd.walk_ev = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = ST_SUMMARY;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = ST_WALK_RD;
                    end
                end
            end
            ST_FLUSH_RD: begin
                n_state = ST_FLUSH_WR;
            end
            ST_FLUSH_WR: begin
                o_cmd.flush_wr = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_SUMMARY;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_FLUSH_RD;
                end
            end
            ST_SUMMARY: begin
                if (i_status.out_free) begin
                    o_cmd.summary = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A closed frame always leaves the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_status.close) |=> (r_state != ST_IDLE))
        else $error("frame close did not start processing");

    // The walk never steps past a key whose event could not be placed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.walk_ev && i_status.emit_want) |-> i_status.out_free)
        else $error("event issued into an occupied output register");

    // The summary is issued only after the last key was handled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.summary |-> ($past(r_state) == ST_WALK_EV || $past(r_state) == ST_FLUSH_WR
                           || $past(r_state) == ST_SUMMARY))
        else $error("summary issued out of sequence");

endmodule

[hw/rtl/kmas_datapath.sv]
// ----------------------------------------------------------------------------
// kmas_datapath
// Registers, sample and timer memories, key walk evaluation and the output
// register of the key matrix autorepeat scanner.
// ----------------------------------------------------------------------------
module kmas_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    // input channel
    input  logic              i_valid,
    input  logic              i_func,
    input  logic              i_key_pressed,
    input  logic [7:0]        i_base_code,
    input  logic [7:0]        i_shifted_code,
    input  logic [7:0]        i_layer_code,
    input  logic              i_caps_lock,
    input  logic [31:0]       i_time_ms,
    input  logic              i_frame_end,
    // output channel
    input  logic              i_ready,
    output logic              o_valid,
    output logic [7:0]        o_event_code,
    output logic [7:0]        o_event_shifted,
    output logic [7:0]        o_event_layer,
    output logic              o_mod_fn,
    output logic              o_mod_ctrl,
    output logic              o_mod_shift,
    output logic              o_mod_alt,
    output logic              o_mod_opt,
    output logic              o_caps_state,
    output logic              o_is_repeat,
    output logic              o_opt_rising,
    output logic              o_last,
    // controller
    input  kmas_pkg::t_cmd    i_cmd,
    output kmas_pkg::t_status o_status
);
    import kmas_pkg::*;

    // Configuration registers.
    logic [15:0] r_delay;
    logic [15:0] r_gap;
    logic [7:0]  r_fn_code;
    logic [7:0]  r_opt_code;
    logic [7:0]  r_ctrl_code;
    logic [7:0]  r_shift_code;
    logic [7:0]  r_alt_code;

    // Frame state.
    logic [CNT_W-1:0]     r_load_idx;
    logic [CNT_W-1:0]     r_loaded;
    logic [KEY_W-1:0]     r_idx;
    logic                 r_caps;
    logic [31:0]          r_now;
    logic [KEY_COUNT-1:0] r_key_down;
    logic [4:0]           r_mod_acc;
    logic [4:0]           r_mods;
    logic                 r_prev_opt;
    logic                 r_rising;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_code;
    logic [7:0] r_out_shifted;
    logic [7:0] r_out_layer;
    logic [4:0] r_out_mods;
    logic       r_out_caps;
    logic       r_out_rep;
    logic       r_out_rising;
    logic       r_out_last;

    logic         accept;
    logic         load_room;
    logic         frame_we;
    t_frame_entry frame_wdata;
    t_frame_entry frame_q;
    logic         timer_we;
    t_timer_entry timer_wdata;
    t_timer_entry timer_q;

    logic        key_pressed;
    logic [4:0]  key_mods;
    logic        key_is_mod;
    logic        new_press;
    logic        rep_due;
    logic [31:0] eff_delay;
    logic [31:0] eff_gap;
    logic [31:0] since_press;
    logic [31:0] since_rep;
    logic        out_free;
    logic        out_load;

    // ------------------------------------------------------------------ load
    assign accept      = i_valid && i_cmd.in_ready;
    assign load_room   = (r_load_idx < CNT_W'(KEY_COUNT));
    assign frame_we    = accept && load_room;
    assign frame_wdata = '{pressed: i_key_pressed, layer: i_layer_code,
                           shifted: i_shifted_code, base: i_base_code};

    kmas_ram #(
        .WIDTH ($bits(t_frame_entry)),
        .DEPTH (KEY_COUNT)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (r_load_idx[KEY_W-1:0]),
        .i_wdata (frame_wdata),
        .i_raddr (r_idx),
        .o_rdata (frame_q)
    );

    kmas_ram #(
        .WIDTH ($bits(t_timer_entry)),
        .DEPTH (KEY_COUNT)
    ) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (timer_we),
        .i_waddr (r_idx),
        .i_wdata (timer_wdata),
        .i_raddr (r_idx),
        .o_rdata (timer_q)
    );

    // ------------------------------------------------------------ evaluation
    // Keys beyond the loaded count of a short frame count as released.
    assign key_pressed = (CNT_W'(r_idx) < r_loaded) && frame_q.pressed;
    assign key_mods    = mod_bits(frame_q.base, r_fn_code, r_ctrl_code, r_shift_code,
                                  r_alt_code, r_opt_code);
    assign key_is_mod  = (key_mods != 5'd0);

    assign eff_delay   = (r_delay == 16'd0) ? DEFAULT_DELAY : {16'd0, r_delay};
    assign eff_gap     = (r_gap == 16'd0) ? DEFAULT_GAP : {16'd0, r_gap};
    assign since_press = r_now - timer_q.press;
    assign since_rep   = r_now - timer_q.rep;

    assign new_press = key_pressed && !key_is_mod && !r_key_down[r_idx];
    assign rep_due   = key_pressed && !key_is_mod && r_key_down[r_idx]
                       && (since_press >= eff_delay) && (since_rep >= eff_gap);

    always_comb begin
        timer_we    = 1'b0;
        timer_wdata = '{press: r_now, rep: r_now};
        if (i_cmd.flush_wr) begin
            timer_we = 1'b1;
        end else if (i_cmd.walk_ev && new_press) begin
            timer_we = 1'b1;
        end else if (i_cmd.walk_ev && rep_due) begin
            timer_we    = 1'b1;
            timer_wdata = '{press: timer_q.press, rep: r_now};
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign out_load = (i_cmd.walk_ev && (new_press || rep_due)) || i_cmd.summary;

    assign o_status = '{close:       accept && i_frame_end,
                        close_flush: i_func,
                        idx_last:    (r_idx == KEY_W'(KEY_COUNT - 1)),
                        emit_want:   new_press || rep_due,
                        out_free:    out_free};

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= RST_DELAY;
            r_gap        <= RST_GAP;
            r_fn_code    <= RST_FN;
            r_opt_code   <= RST_OPT;
            r_ctrl_code  <= RST_CTRL;
            r_shift_code <= RST_SHIFT;
            r_alt_code   <= RST_ALT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DELAY: r_delay      <= i_cfg_data;
                CFG_GAP:   r_gap        <= i_cfg_data;
                CFG_FN:    r_fn_code    <= i_cfg_data[7:0];
                CFG_OPT:   r_opt_code   <= i_cfg_data[7:0];
                CFG_CTRL:  r_ctrl_code  <= i_cfg_data[7:0];
                CFG_SHIFT: r_shift_code <= i_cfg_data[7:0];
                CFG_ALT:   r_alt_code   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_key_down <= '0;
            r_mods     <= '0;
            r_prev_opt <= 1'b0;
            r_rising   <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (accept) begin
                if (i_frame_end) begin
                    r_load_idx <= '0;
                    r_rising   <= 1'b0;
                end else if (load_room) begin
                    r_load_idx <= r_load_idx + CNT_W'(1);
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + KEY_W'(1);
            end
            if (i_cmd.mod_fin) begin
                r_mods     <= r_mod_acc;
                r_rising   <= r_mod_acc[MOD_OPT] && !r_prev_opt;
                r_prev_opt <= r_mod_acc[MOD_OPT];
            end
            if (i_cmd.flush_wr) begin
                r_key_down[r_idx] <= key_pressed;
            end else if (i_cmd.walk_ev) begin
                r_key_down[r_idx] <= key_pressed;
            end
        end
    end

    // Frame values taken from the closing item, and the modifier accumulator.
    always_ff @(posedge i_clk) begin
        if (accept && i_frame_end) begin
            r_caps    <= i_caps_lock;
            r_now     <= i_time_ms;
            r_loaded  <= r_load_idx + CNT_W'(load_room);
            r_mod_acc <= '0;
        end else if (i_cmd.mod_acc && key_pressed) begin
            r_mod_acc <= r_mod_acc | key_mods;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mods   <= r_mods;
            r_out_caps   <= r_caps;
            r_out_rising <= r_rising;
            if (i_cmd.summary) begin
                r_out_code    <= 8'd0;
                r_out_shifted <= 8'd0;
                r_out_layer   <= 8'd0;
                r_out_rep     <= 1'b0;
                r_out_last    <= 1'b1;
            end else begin
                r_out_code    <= frame_q.base;
                r_out_shifted <= frame_q.shifted;
                r_out_layer   <= frame_q.layer;
                r_out_rep     <= rep_due;
                r_out_last    <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_code    = r_out_code;
    assign o_event_shifted = r_out_shifted;
    assign o_event_layer   = r_out_layer;
    assign o_mod_fn        = r_out_mods[MOD_FN];
    assign o_mod_ctrl      = r_out_mods[MOD_CTRL];
    assign o_mod_shift     = r_out_mods[MOD_SHIFT];
    assign o_mod_alt       = r_out_mods[MOD_ALT];
    assign o_mod_opt       = r_out_mods[MOD_OPT];
    assign o_caps_state    = r_out_caps;
    assign o_is_repeat     = r_out_rep;
    assign o_opt_rising    = r_out_rising;
    assign o_last          = r_out_last;

    // The load pointer never runs past the key count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_idx <= CNT_W'(KEY_COUNT))
        else $error("load index past key count");

    // A closing item rewinds the load pointer for the next frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_end) |=> (r_load_idx == '0))
        else $error("load index not rewound at frame close");

    // A result held for the receiver is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> i_ready)
        else $error("output register overwritten");

endmodule

[hw/rtl/key_matrix_autorepeat_scanner_top.sv]
// ----------------------------------------------------------------------------
// key_matrix_autorepeat_scanner_top
// Keyboard matrix scanner with press events and typematic autorepeat.
// ----------------------------------------------------------------------------
// Usage: send one item per matrix key per scan frame, in key order, on the
// i_valid/o_ready channel; the item with i_frame_end set closes the frame and
// supplies the frame's function, caps lock state and millisecond time.
// A sample item that does not close a frame gives no result. At the close
// the block runs a modifier pass and then walks all keys, and it takes no
// further item until both passes and the summary are done; a flush frame
// needs only the flush pass. Each pass reads every key once through the
// single read port of the sample and timer memories and acts on it after
// the registered read. Results (press events, repeat events, then the
// summary flagged with o_last) leave through a one-deep output register on
// o_valid/i_ready. While the receiver stalls, the walk waits on the key that
// has an event; a summary waiting for that register holds off the next
// frame's samples, but once placed it does not stop their loading.
// Reset (synchronous, active low) clears all keys to released, the modifier
// state and the load pointer, and restores the register defaults. The timer
// memory is not cleared: a flush frame or a press event sets a key's timers.
// Registers are written on the i_cfg_valid/o_cfg_ready channel, which is
// always ready; writes are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module key_matrix_autorepeat_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // key sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_key_pressed,
    input  logic [7:0]  i_base_code,
    input  logic [7:0]  i_shifted_code,
    input  logic [7:0]  i_layer_code,
    input  logic        i_caps_lock,
    input  logic [31:0] i_time_ms,
    input  logic        i_frame_end,
    // event channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_event_code,
    output logic [7:0]  o_event_shifted,
    output logic [7:0]  o_event_layer,
    output logic        o_mod_fn,
    output logic        o_mod_ctrl,
    output logic        o_mod_shift,
    output logic        o_mod_alt,
    output logic        o_mod_opt,
    output logic        o_caps_state,
    output logic        o_is_repeat,
    output logic        o_opt_rising,
    output logic        o_last
);
    import kmas_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller only sequences; all storage sits in the datapath.
    kmas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kmas_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_func          (i_func),
        .i_key_pressed   (i_key_pressed),
        .i_base_code     (i_base_code),
        .i_shifted_code  (i_shifted_code),
        .i_layer_code    (i_layer_code),
        .i_caps_lock     (i_caps_lock),
        .i_time_ms       (i_time_ms),
        .i_frame_end     (i_frame_end),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_event_code    (o_event_code),
        .o_event_shifted (o_event_shifted),
        .o_event_layer   (o_event_layer),
        .o_mod_fn        (o_mod_fn),
        .o_mod_ctrl      (o_mod_ctrl),
        .o_mod_shift     (o_mod_shift),
        .o_mod_alt       (o_mod_alt),
        .o_mod_opt       (o_mod_opt),
        .o_caps_state    (o_caps_state),
        .o_is_repeat     (o_is_repeat),
        .o_opt_rising    (o_opt_rising),
        .o_last          (o_last),
        .i_cmd           (cmd),
        .o_status        (status)
    );

    // Samples are taken only while the controller waits for the next item.
    assign o_ready     = cmd.in_ready;
    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

endmodule

[test/tb_key_matrix_autorepeat_scanner_top.sv]
// ----------------------------------------------------------------------------
// tb_key_matrix_autorepeat_scanner_top
// Self-checking bench for the key matrix scanner with typematic autorepeat.
// Key samples are queued frame by frame and driven on the sample channel. An
// in-bench scanner model turns every accepted sample into the press, repeat
// and summary results it must cause, and every result leaving the event
// channel is checked field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_key_matrix_autorepeat_scanner_top;

    import kmas_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 1_000_000;
    // Wait for twice the length of a frame close before touching the
    // registers or ending the run.
    localparam int SETTLE_CYCLES = 2 * (4 * KEY_COUNT + 3);
    localparam int PHASE_ITEMS   = 58;
    localparam int HOLD_CYCLES   = 2000;

    // One key sample as it travels on the sample channel.
    typedef struct {
        bit        func;
        bit        pressed;
        bit [7:0]  base;
        bit [7:0]  shifted;
        bit [7:0]  layer;
        bit        caps;
        bit [31:0] stamp;
        bit        fend;
    } t_sample;

    // One result as it leaves the event channel.
    typedef struct {
        bit [7:0] code;
        bit [7:0] shifted;
        bit [7:0] layer;
        bit       fn;
        bit       ctrl;
        bit       shift;
        bit       alt;
        bit       opt;
        bit       caps;
        bit       rep;
        bit       rising;
        bit       last;
    } t_key_event;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic        i_func         = 1'b0;
    logic        i_key_pressed  = 1'b0;
    logic [7:0]  i_base_code    = '0;
    logic [7:0]  i_shifted_code = '0;
    logic [7:0]  i_layer_code   = '0;
    logic        i_caps_lock    = 1'b0;
    logic [31:0] i_time_ms      = '0;
    logic        i_frame_end    = 1'b0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [7:0]  o_event_code;
    logic [7:0]  o_event_shifted;
    logic [7:0]  o_event_layer;
    logic        o_mod_fn;
    logic        o_mod_ctrl;
    logic        o_mod_shift;
    logic        o_mod_alt;
    logic        o_mod_opt;
    logic        o_caps_state;
    logic        o_is_repeat;
    logic        o_opt_rising;
    logic        o_last;

    key_matrix_autorepeat_scanner_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_key_pressed   (i_key_pressed),
        .i_base_code     (i_base_code),
        .i_shifted_code  (i_shifted_code),
        .i_layer_code    (i_layer_code),
        .i_caps_lock     (i_caps_lock),
        .i_time_ms       (i_time_ms),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_code    (o_event_code),
        .o_event_shifted (o_event_shifted),
        .o_event_layer   (o_event_layer),
        .o_mod_fn        (o_mod_fn),
        .o_mod_ctrl      (o_mod_ctrl),
        .o_mod_shift     (o_mod_shift),
        .o_mod_alt       (o_mod_alt),
        .o_mod_opt       (o_mod_opt),
        .o_caps_state    (o_caps_state),
        .o_is_repeat     (o_is_repeat),
        .o_opt_rising    (o_opt_rising),
        .o_last          (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------------
    t_sample    pending_samples[$];   // items waiting to be driven
    t_key_event owed_events[$];       // results the block still has to give
    int         n_sent      = 0;      // items put on the sample channel
    int         n_taken     = 0;      // items the block accepted
    int         n_fail      = 0;
    int         n_presses   = 0;
    int         n_repeats   = 0;
    int         n_summaries = 0;
    int         n_settings  = 1;      // the reset values count as one
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         hold_req    = 1'b0;   // ask the receiver for one long stall
    bit         hold_done   = 1'b0;
    int         hold_left   = 0;

    // ------------------------------------------------------------------------
    // Scanner model: register copies and key state, as they are after reset.
    // ------------------------------------------------------------------------
    bit [15:0] reg_delay = RST_DELAY;
    bit [15:0] reg_gap   = RST_GAP;
    bit [7:0]  reg_fn    = RST_FN;
    bit [7:0]  reg_opt   = RST_OPT;
    bit [7:0]  reg_ctrl  = RST_CTRL;
    bit [7:0]  reg_shift = RST_SHIFT;
    bit [7:0]  reg_alt   = RST_ALT;

    bit        key_is_down[KEY_COUNT];
    bit [31:0] press_at[KEY_COUNT];
    bit [31:0] repeat_at[KEY_COUNT];
    bit        latched_pressed[KEY_COUNT];
    bit [23:0] latched_codes[KEY_COUNT];   // {layer, shifted, base}
    bit [4:0]  mod_flags    = '0;
    bit        opt_was_held = 1'b0;
    int        load_ptr     = 0;

    // Which modifier flags a base code raises. One code may raise several
    // flags when registers share a value.
    function automatic bit [4:0] modifier_hits(bit [7:0] code);
        bit [4:0] hits;
        hits            = '0;
        hits[MOD_FN]    = (code == reg_fn);
        hits[MOD_CTRL]  = (code == reg_ctrl);
        hits[MOD_SHIFT] = (code == reg_shift);
        hits[MOD_ALT]   = (code == reg_alt);
        hits[MOD_OPT]   = (code == reg_opt);
        return hits;
    endfunction

    function automatic t_key_event form_event(bit [23:0] codes, bit caps, bit rep,
                                              bit rising, bit last);
        t_key_event ev;
        ev.code    = codes[7:0];
        ev.shifted = codes[15:8];
        ev.layer   = codes[23:16];
        ev.fn      = mod_flags[MOD_FN];
        ev.ctrl    = mod_flags[MOD_CTRL];
        ev.shift   = mod_flags[MOD_SHIFT];
        ev.alt     = mod_flags[MOD_ALT];
        ev.opt     = mod_flags[MOD_OPT];
        ev.caps    = caps;
        ev.rep     = rep;
        ev.rising  = rising;
        ev.last    = last;
        return ev;
    endfunction

    // Latches one sample and, on a frame close, works out every result of
    // the frame in the order the block has to give them.
    task automatic predict_frame(t_sample s);
        int        loaded;
        bit        rising;
        bit [31:0] hold_ms;
        bit [31:0] gap_ms;
        bit        emit;
        bit        rep;
        if (load_ptr < KEY_COUNT) begin
            latched_pressed[load_ptr] = s.pressed;
            latched_codes[load_ptr]   = {s.layer, s.shifted, s.base};
            load_ptr++;
        end
        if (!s.fend) begin
            return;
        end
        loaded   = load_ptr;
        load_ptr = 0;

        // A flush frame resynchronizes the keys and gives only the summary; flags are kept.
        if (s.func) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                key_is_down[i] = (i < loaded) && latched_pressed[i];
                press_at[i]    = s.stamp;
                repeat_at[i]   = s.stamp;
            end
            owed_events.insert(owed_events.size(),
                               form_event('0, s.caps, 1'b0, 1'b0, 1'b1));
            return;
        end

        mod_flags = '0;
        for (int i = 0; i < loaded; i++) begin
            if (latched_pressed[i]) begin
                mod_flags |= modifier_hits(latched_codes[i][7:0]);
            end
        end
        rising       = mod_flags[MOD_OPT] && !opt_was_held;
        opt_was_held = mod_flags[MOD_OPT];

        hold_ms = (reg_delay != 0) ? 32'(reg_delay) : DEFAULT_DELAY;
        gap_ms  = (reg_gap != 0) ? 32'(reg_gap) : DEFAULT_GAP;
        for (int i = 0; i < KEY_COUNT; i++) begin
            emit = 1'b0;
            rep  = 1'b0;
            if (i >= loaded || !latched_pressed[i]) begin
                key_is_down[i] = 1'b0;
            end else if (modifier_hits(latched_codes[i][7:0]) != '0) begin
                key_is_down[i] = 1'b1;
            end else if (!key_is_down[i]) begin
                key_is_down[i] = 1'b1;
                press_at[i]    = s.stamp;
                repeat_at[i]   = s.stamp;
                emit           = 1'b1;
            end else if ((s.stamp - press_at[i]) >= hold_ms &&
                         (s.stamp - repeat_at[i]) >= gap_ms) begin
                repeat_at[i] = s.stamp;
                emit         = 1'b1;
                rep          = 1'b1;
            end
            if (emit) begin
                owed_events.insert(owed_events.size(),
                                   form_event(latched_codes[i], s.caps, rep,
                                              rising, 1'b0));
            end
        end
        owed_events.insert(owed_events.size(),
                           form_event('0, s.caps, 1'b0, rising, 1'b1));
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample driver. Inputs move on the falling edge only. A new item goes
    // out once the previous one was taken, unless the sender idles this cycle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_sample nxt;
        if (!i_valid || n_taken == n_sent) begin
            if (pending_samples.size() != 0 &&
                int'($urandom_range(99)) >= tx_idle_pct) begin
                nxt = pending_samples.pop_front();
                i_valid        <= 1'b1;
                i_func         <= nxt.func;
                i_key_pressed  <= nxt.pressed;
                i_base_code    <= nxt.base;
                i_shifted_code <= nxt.shifted;
                i_layer_code   <= nxt.layer;
                i_caps_lock    <= nxt.caps;
                i_time_ms      <= nxt.stamp;
                i_frame_end    <= nxt.fend;
                n_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event receiver. It stalls at random, and once on request holds off for
    // a long stretch so the output register fills and the sample channel
    // backs up.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Results are checked before the sample of the same edge is
    // predicted; a result can never stem from a sample taken at that edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_key_event want;
        t_sample    seen;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (owed_events.size() == 0) begin
                    $error("result with no expectation waiting: code %0h last %0b",
                           o_event_code, o_last);
                    n_fail++;
                end else begin
                    want = owed_events.pop_front();
                    check_field("event_code", want.code, o_event_code);
                    check_field("event_shifted", want.shifted, o_event_shifted);
                    check_field("event_layer", want.layer, o_event_layer);
                    check_field("mod_fn", 8'(want.fn), 8'(o_mod_fn));
                    check_field("mod_ctrl", 8'(want.ctrl), 8'(o_mod_ctrl));
                    check_field("mod_shift", 8'(want.shift), 8'(o_mod_shift));
                    check_field("mod_alt", 8'(want.alt), 8'(o_mod_alt));
                    check_field("mod_opt", 8'(want.opt), 8'(o_mod_opt));
                    check_field("caps_state", 8'(want.caps), 8'(o_caps_state));
                    check_field("is_repeat", 8'(want.rep), 8'(o_is_repeat));
                    check_field("opt_rising", 8'(want.rising), 8'(o_opt_rising));
                    check_field("last", 8'(want.last), 8'(o_last));
                    if (want.last) begin
                        n_summaries++;
                    end else if (want.rep) begin
                        n_repeats++;
                    end else begin
                        n_presses++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                seen.func    = i_func;
                seen.pressed = i_key_pressed;
                seen.base    = i_base_code;
                seen.shifted = i_shifted_code;
                seen.layer   = i_layer_code;
                seen.caps    = i_caps_lock;
                seen.stamp   = i_time_ms;
                seen.fend    = i_frame_end;
                predict_frame(seen);
                n_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation. Each key index keeps a code map and a held bit, so
    // frames form believable typing: keys stay down over several frames and
    // autorepeat, modifiers come and go, time moves forward and sometimes
    // jumps or wraps.
    // ------------------------------------------------------------------------
    bit [7:0]  map_base[KEY_COUNT];
    bit [7:0]  map_shifted[KEY_COUNT];
    bit [7:0]  map_layer[KEY_COUNT];
    bit        held_now[KEY_COUNT];
    bit [31:0] scan_clock = '0;

    // Queues one frame of n_keys samples. Beyond KEY_COUNT the samples
    // wrap over the map; the block must drop them. Noisy frames scramble
    // some samples and the fields that only the closing item carries.
    task automatic queue_frame(int n_keys, bit flush, bit [31:0] stamp, bit caps,
                               bit noisy);
        t_sample s;
        int      k;
        for (int i = 0; i < n_keys; i++) begin
            k         = i % KEY_COUNT;
            s.pressed = held_now[k];
            s.base    = map_base[k];
            s.shifted = map_shifted[k];
            s.layer   = map_layer[k];
            if (noisy && $urandom_range(19) == 0) begin
                s.pressed = 1'($urandom_range(1));
                s.base    = 8'($urandom_range(255));
                s.shifted = 8'($urandom_range(255));
                s.layer   = 8'($urandom_range(255));
            end
            s.fend  = (i == n_keys - 1);
            s.func  = s.fend ? flush : (noisy ? 1'($urandom_range(1)) : 1'b0);
            s.caps  = s.fend ? caps : (noisy ? 1'($urandom_range(1)) : 1'b0);
            s.stamp = s.fend ? stamp : (noisy ? 32'($urandom) : 32'd0);
            pending_samples.insert(pending_samples.size(), s);
        end
    endtask

    // Fresh codes for every key; some keys carry a current modifier code.
    task automatic new_keymap();
        for (int k = 0; k < KEY_COUNT; k++) begin
            map_base[k]    = 8'($urandom_range(255));
            map_shifted[k] = 8'($urandom_range(255));
            map_layer[k]   = 8'($urandom_range(255));
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(4))
                    0: map_base[k] = reg_fn;
                    1: map_base[k] = reg_ctrl;
                    2: map_base[k] = reg_shift;
                    3: map_base[k] = reg_alt;
                    default: map_base[k] = reg_opt;
                endcase
            end
        end
    endtask

    task automatic random_frames(int n_items);
        int made;
        int n_keys;
        int pick;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                n_keys = KEY_COUNT;
            end else if (pick < 10) begin
                n_keys = $urandom_range(KEY_COUNT + 4, KEY_COUNT + 1);
            end else begin
                n_keys = $urandom_range(8, 1);
            end
            for (int k = 0; k < KEY_COUNT; k++) begin
                if ($urandom_range(99) < 20) begin
                    held_now[k] = !held_now[k];
                end
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                scan_clock += $urandom_range(400);
            end else if (pick < 85) begin
                scan_clock += $urandom_range(3000, 400);
            end else if (pick < 95) begin
                scan_clock += $urandom;
            end else begin
                scan_clock += 32'd70000;
            end
            queue_frame(n_keys, $urandom_range(99) < 8, scan_clock,
                        1'($urandom_range(1)), 1'b1);
            made += n_keys;
            if ($urandom_range(99) < 5) begin
                new_keymap();
            end
        end
    endtask

    // Waits until every item is out and every owed result has arrived, then
    // lets the block finish any frame work that produces nothing more.
    task automatic drain();
        while (pending_samples.size() != 0 || i_valid || owed_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DELAY: reg_delay = value;
            CFG_GAP:   reg_gap   = value;
            CFG_FN:    reg_fn    = value[7:0];
            CFG_OPT:   reg_opt   = value[7:0];
            CFG_CTRL:  reg_ctrl  = value[7:0];
            CFG_SHIFT: reg_shift = value[7:0];
            CFG_ALT:   reg_alt   = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(bit [15:0] dly, bit [15:0] gap, bit [7:0] fn,
                                 bit [7:0] opt, bit [7:0] ctrl, bit [7:0] shf,
                                 bit [7:0] alt);
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_FN, 16'(fn));
        write_reg(CFG_OPT, 16'(opt));
        write_reg(CFG_CTRL, 16'(ctrl));
        write_reg(CFG_SHIFT, 16'(shf));
        write_reg(CFG_ALT, 16'(alt));
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_is_down[k] = 1'b0;
            held_now[k]    = 1'b0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values, sender rarely
        // idle and receiver often stalled.
        tx_idle_pct = 7;
        rx_idle_pct = 53;
        map_base[0] = 8'h41; map_shifted[0] = 8'hFF; map_layer[0] = 8'h00;
        map_base[1] = RST_SHIFT; map_shifted[1] = 8'h00; map_layer[1] = 8'hFF;
        map_base[2] = RST_OPT; map_shifted[2] = 8'h5A; map_layer[2] = 8'hA5;
        map_base[3] = RST_ALT; map_shifted[3] = 8'h01; map_layer[3] = 8'h80;

        // A flush frame first writes the timers of every key, so no key can
        // later be read with timers that were never set.
        queue_frame(1, 1'b1, 32'd0, 1'b0, 1'b0);
        // Fresh press of a letter with shift and opt held: opt rises.
        held_now[0] = 1'b1; held_now[1] = 1'b1; held_now[2] = 1'b1;
        queue_frame(3, 1'b0, 32'd1000, 1'b1, 1'b0);
        // One millisecond short of the hold delay: nothing but the summary.
        queue_frame(3, 1'b0, 32'd1499, 1'b0, 1'b0);
        // Delay reached exactly: the first repeat.
        queue_frame(3, 1'b0, 32'd1500, 1'b1, 1'b0);
        // Held modifiers change identity to fn and ctrl, alt comes down;
        // time sits at the top of the clock.
        map_base[1] = RST_FN;
        map_base[2] = RST_CTRL;
        held_now[3] = 1'b1;
        queue_frame(4, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // Short frame across the clock wrap: the interval is met exactly
        // and every key not loaded counts as released.
        queue_frame(1, 1'b0, 32'd99, 1'b0, 1'b0);
        // Flush with two letters held marks them down silently.
        map_base[1] = 8'h10; map_shifted[1] = 8'h11; map_layer[1] = 8'h12;
        queue_frame(2, 1'b1, 32'd5000, 1'b1, 1'b0);
        // Both keys already down and too young to repeat.
        queue_frame(2, 1'b0, 32'd5100, 1'b0, 1'b0);
        scan_clock = 32'd5100;
        drain();

        // Zero delay and interval stand in for the defaults.
        set_registers(16'd0, 16'd0, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4);
        new_keymap();
        random_frames(PHASE_ITEMS);
        drain();

        // The other way round: slow sender, eager receiver. Largest timing
        // values and modifier codes that share values at both code extremes.
        tx_idle_pct = 53;
        rx_idle_pct = 7;
        set_registers(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80);
        new_keymap();
        random_frames(PHASE_ITEMS);
        drain();

        // No idling on either side; fastest repeats, and one long receiver
        // stall while samples keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_registers(16'd1, 16'd1, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        new_keymap();
        hold_req = 1'b1;
        random_frames(PHASE_ITEMS);
        drain();

        // Random register values, still without idling.
        set_registers(16'($urandom_range(2000)), 16'($urandom_range(300)),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        new_keymap();
        random_frames(PHASE_ITEMS);
        drain();

        $display("Run covered %0d sample items over %0d frames and %0d register settings.",
                 n_taken, n_summaries, n_settings);
        $display("Checked %0d press events and %0d repeat events; %0d field mismatches.",
                 n_presses, n_repeats, n_fail);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kmas_pkg.sv
hw/rtl/kmas_ram.sv
hw/rtl/kmas_ctrl.sv
hw/rtl/kmas_datapath.sv
hw/rtl/key_matrix_autorepeat_scanner_top.sv
test/tb_key_matrix_autorepeat_scanner_top.sv
